@@ src/seard_pkg.sv @@
package seard_pkg;

	localparam int MAX_DIMS_DEF = 16;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_COORD = 1'b1;

	localparam logic [1:0] CFG_OUTPUT_SCALE = 2'd0;
	localparam logic [1:0] CFG_DERIV_SELECT = 2'd1;
	localparam logic [1:0] CFG_NUM_DIMS     = 2'd2;

	localparam logic [15:0] OUTPUT_SCALE_RST = 16'd256;
	localparam logic [4:0]  NUM_DIMS_RST     = 5'd1;

	localparam logic [15:0] INV_TWO_LN2_Q16 = 16'd47274;
	localparam logic [15:0] LN2_Q16         = 16'd45426;

	typedef struct packed {
		logic              operation;
		logic [3:0]        dim_index;
		logic signed [15:0] coord_a;
		logic signed [15:0] coord_b;
		logic [15:0]       scale_value;
		logic              last_element;
	} in_item_t;

	typedef struct packed {
		logic [31:0] kernel_value;
		logic        index_error;
		logic        saturated;
	} out_item_t;

	typedef struct packed {
		logic cap;
		logic vmul;
		logic tmul;
		logic acc;
		logic e1;
		logic e2;
		logic e3;
		logic e4;
		logic e5;
		logic e6;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} status_t;

	// 2^(-i/16) in Q0.16 (first entry is 1.0, needs 17 bits)
	function automatic logic [16:0] pow2_frac(input logic [3:0] i);
		logic [16:0] r;
		unique case (i)
			4'd0:  r = 17'd65536;
			4'd1:  r = 17'd62757;
			4'd2:  r = 17'd60097;
			4'd3:  r = 17'd57549;
			4'd4:  r = 17'd55109;
			4'd5:  r = 17'd52773;
			4'd6:  r = 17'd50535;
			4'd7:  r = 17'd48393;
			4'd8:  r = 17'd46341;
			4'd9:  r = 17'd44376;
			4'd10: r = 17'd42495;
			4'd11: r = 17'd40693;
			4'd12: r = 17'd38968;
			4'd13: r = 17'd37316;
			4'd14: r = 17'd35734;
			default: r = 17'd34219;
		endcase
		return r;
	endfunction

endpackage

@@ src/se_ard_covariance_kernel_top.sv @@
// channel  dir  handshake            payload
// in       in   in_valid / in_stall   in_item  (seard_pkg::in_item_t)
// out      out  out_valid / out_stall out_item (seard_pkg::out_item_t)
// cfg      in   cfg_we                cfg_index, cfg_data
//
// A load item is taken without leaving the idle state. A coordinate item runs
// through VMUL, TMUL and ACC; one marked last goes on through E1 to E6 and FIN.
// The last item's result waits in the output register; a stalled output holds
// the final state, earlier items still go through.
// Reset loads config defaults, clears accumulators and control; scale table has no reset.
module se_ard_covariance_kernel_top #(
	parameter int MAX_DIMS = seard_pkg::MAX_DIMS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  seard_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output seard_pkg::out_item_t out_item,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	seard_pkg::cmd_t    cmd;
	seard_pkg::status_t status;

	seard_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_item.operation),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	seard_dp #(.MAX_DIMS(MAX_DIMS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_item.operation == seard_pkg::OP_LOAD) |=> !in_stall)
		else $error("load item did not finish in one cycle");

	a_coord_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_item.operation == seard_pkg::OP_COORD) |=> in_stall)
		else $error("coordinate item not held busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.index_error) |-> (out_item.kernel_value == 32'd0))
		else $error("index error with nonzero value");

endmodule

@@ src/seard_ram.sv @@
module seard_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/seard_ctrl.sv @@
module seard_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_op,
	output logic             in_stall,
	input  seard_pkg::status_t status,
	output seard_pkg::cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_VMUL = 11'b000_0000_0010,
		S_TMUL = 11'b000_0000_0100,
		S_ACC  = 11'b000_0000_1000,
		S_E1   = 11'b000_0001_0000,
		S_E2   = 11'b000_0010_0000,
		S_E3   = 11'b000_0100_0000,
		S_E4   = 11'b000_1000_0000,
		S_E5   = 11'b001_0000_0000,
		S_E6   = 11'b010_0000_0000,
		S_FIN  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.cap = accept;
		unique case (state_q)
			S_IDLE: begin
				if (accept && in_op == seard_pkg::OP_COORD) state_d = S_VMUL;
			end
			S_VMUL: begin
				cmd.vmul = 1'b1;
				state_d  = S_TMUL;
			end
			S_TMUL: begin
				cmd.tmul = 1'b1;
				state_d  = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = status.last ? S_E1 : S_IDLE;
			end
			S_E1: begin
				cmd.e1  = 1'b1;
				state_d = S_E2;
			end
			S_E2: begin
				cmd.e2  = 1'b1;
				state_d = S_E3;
			end
			S_E3: begin
				cmd.e3  = 1'b1;
				state_d = S_E4;
			end
			S_E4: begin
				cmd.e4  = 1'b1;
				state_d = S_E5;
			end
			S_E5: begin
				cmd.e5  = 1'b1;
				state_d = S_E6;
			end
			S_E6: begin
				cmd.e6  = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/seard_dp.sv @@
module seard_dp #(
	parameter int MAX_DIMS = seard_pkg::MAX_DIMS_DEF,
	localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  seard_pkg::in_item_t in_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  seard_pkg::cmd_t     cmd,
	output seard_pkg::status_t  status,
	output logic                out_valid,
	input  logic                out_stall,
	output seard_pkg::out_item_t out_item
);

	logic [15:0] out_scale_q;
	logic [4:0]  deriv_sel_q;
	logic [4:0]  num_dims_q;

	logic [AW+3:0] dim_wide;
	logic [AW-1:0] dim_addr;
	logic          dim_in_ok;
	logic [15:0]   scale_rd;

	logic [15:0] mag_q;
	logic [3:0]  dim_q;
	logic        dim_ok_q;
	logic        last_q;
	logic [27:0] v_q;
	logic [31:0] term_q;
	logic        term_sat_q;
	logic [31:0] dsum_q;
	logic [31:0] sel_term_q;
	logic        sat_q;
	logic [31:0] t_q;
	logic [11:0] lr_q;
	logic [15:0] n_q;
	logic [3:0]  i_q;
	logic [16:0] p_q;
	logic [17:0] m_q;
	logic [15:0] e_q;
	logic [23:0] base_q;
	logic        out_valid_q;
	seard_pkg::out_item_t out_q;

	logic signed [16:0] diff;
	logic [31:0] vprod;
	logic [55:0] sq;
	logic [32:0] sum33;
	logic [47:0] tprod;
	logic [27:0] lrprod;
	logic [23:0] lrsq;
	logic [33:0] mprod;
	logic [17:0] m_shift;
	logic [31:0] bprod;
	logic [55:0] dprod;
	logic [5:0]  nd_plus1;
	seard_pkg::out_item_t res;

	assign dim_wide  = (AW+4)'(in_item.dim_index);
	assign dim_addr  = dim_wide[AW-1:0];
	assign dim_in_ok = (32'(in_item.dim_index) < MAX_DIMS);

	seard_ram #(.WIDTH(16), .DEPTH(MAX_DIMS)) u_scale_ram (
		.clk   (clk),
		.we    (cmd.cap && in_item.operation == seard_pkg::OP_LOAD && dim_in_ok),
		.waddr (dim_addr),
		.wdata (in_item.scale_value),
		.re    (cmd.cap),
		.raddr (dim_addr),
		.rdata (scale_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_scale_q <= seard_pkg::OUTPUT_SCALE_RST;
			deriv_sel_q <= '0;
			num_dims_q  <= seard_pkg::NUM_DIMS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				seard_pkg::CFG_OUTPUT_SCALE: out_scale_q <= cfg_data;
				seard_pkg::CFG_DERIV_SELECT: deriv_sel_q <= cfg_data[4:0];
				seard_pkg::CFG_NUM_DIMS:     num_dims_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign diff   = {in_item.coord_a[15], in_item.coord_a} - {in_item.coord_b[15], in_item.coord_b};
	assign vprod  = 32'(mag_q) * 32'(scale_rd);
	assign sq     = 56'(v_q) * 56'(v_q);
	assign sum33  = {1'b0, dsum_q} + {1'b0, term_q};
	assign tprod  = 48'(dsum_q) * 48'(seard_pkg::INV_TWO_LN2_Q16);
	assign lrprod = 28'(t_q[11:0]) * 28'(seard_pkg::LN2_Q16);
	assign lrsq   = 24'(lr_q) * 24'(lr_q);
	assign mprod  = 34'(seard_pkg::pow2_frac(i_q)) * 34'(p_q);
	assign m_shift = m_q >> n_q[4:0];
	assign bprod  = 32'(out_scale_q) * 32'(e_q);
	assign dprod  = 56'(base_q) * 56'(sel_term_q);
	assign nd_plus1 = 6'(num_dims_q) + 6'd1;

	always_comb begin
		res = '0;
		res.saturated = sat_q;
		if (deriv_sel_q == 5'd0) begin
			res.kernel_value = 32'(base_q);
		end else if (deriv_sel_q <= num_dims_q) begin
			if (|dprod[55:48]) begin
				res.kernel_value = '1;
				res.saturated    = 1'b1;
			end else begin
				res.kernel_value = dprod[47:16];
			end
		end else if (6'(deriv_sel_q) == nd_plus1) begin
			res.kernel_value = {7'd0, base_q, 1'b0};
		end else begin
			res.index_error = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mag_q    <= diff[16] ? 16'(-diff) : diff[15:0];
			dim_q    <= in_item.dim_index;
			dim_ok_q <= dim_in_ok;
			last_q   <= in_item.last_element;
		end
		if (cmd.vmul) v_q <= vprod[31:4];
		if (cmd.tmul) begin
			term_sat_q <= |sq[55:48];
			term_q     <= (|sq[55:48]) ? '1 : sq[47:16];
		end
		if (cmd.e1) t_q <= tprod[47:16];
		if (cmd.e2) begin
			lr_q <= lrprod[27:16];
			n_q  <= t_q[31:16];
			i_q  <= t_q[15:12];
		end
		if (cmd.e3) p_q <= 17'd65536 - 17'(lr_q) + 17'(lrsq[23:17]);
		if (cmd.e4) m_q <= mprod[33:16];
		if (cmd.e5) begin
			if (n_q > 16'd16) e_q <= '0;
			else if (|m_shift[17:16]) e_q <= '1;
			else e_q <= m_shift[15:0];
		end
		if (cmd.e6) base_q <= bprod[31:8];
		if (cmd.fin) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsum_q      <= '0;
			sel_term_q  <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.acc && dim_ok_q) begin
				dsum_q <= sum33[32] ? '1 : sum33[31:0];
				sat_q  <= sat_q | sum33[32] | term_sat_q;
				if (deriv_sel_q != 5'd0 && 5'(deriv_sel_q - 5'd1) == 5'(dim_q)) begin
					sel_term_q <= term_q;
				end
			end
			if (cmd.fin) begin
				dsum_q     <= '0;
				sel_term_q <= '0;
				sat_q      <= 1'b0;
			end
			if (cmd.fin) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign status.last     = last_q;
	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign out_item        = out_q;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_LEN = 300;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	seard_pkg::in_item_t in_item;
	logic out_valid;
	logic out_stall;
	seard_pkg::out_item_t out_item;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	se_ard_covariance_kernel_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0] m_out_scale;
	logic [4:0] m_deriv_sel;
	logic [4:0] m_num_dims;
	logic [15:0] m_scales [16];
	logic [31:0] m_dist;
	logic [31:0] m_sel_term;
	logic m_sat;

	seard_pkg::in_item_t pending_items[$];
	seard_pkg::out_item_t expected_kernels[$];
	int errors;
	int in_idle_pct;
	int out_idle_pct;
	int hold_cycles;
	int idle_cycles;
	bit in_taken;
	bit hold_req;
	bit hold_used;

	const logic [16:0] POW2_TAB [16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
		48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};

	function automatic logic [31:0] clip_u32(input logic [63:0] v, inout logic sat);
		if (v > 64'hFFFF_FFFF) begin
			sat = 1'b1;
			return 32'hFFFF_FFFF;
		end
		return v[31:0];
	endfunction

	function automatic logic [15:0] exp_half_neg(input logic [31:0] d);
		logic [63:0] t;
		logic [47:0] n;
		logic [15:0] f;
		logic [11:0] r;
		logic [31:0] lr;
		logic [31:0] p;
		logic [63:0] m;
		logic [31:0] e;
		t = (64'(d) * 64'd47274) >> 16;
		n = t[63:16];
		f = t[15:0];
		r = f[11:0];
		lr = (32'(r) * 32'd45426) >> 16;
		p = 32'd65536 - lr + ((lr * lr) >> 17);
		m = (64'(POW2_TAB[f[15:12]]) * 64'(p)) >> 16;
		if (n > 16)
			e = 0;
		else
			e = m[31:0] >> n;
		if (e > 65535)
			e = 65535;
		return e[15:0];
	endfunction

	task automatic predict_kernel(input seard_pkg::in_item_t it);
		logic signed [16:0] diff;
		logic [16:0] mag;
		logic [63:0] v;
		logic [31:0] term;
		logic [63:0] base;
		logic s;
		seard_pkg::out_item_t res;
		if (it.operation == seard_pkg::OP_LOAD) begin
			m_scales[it.dim_index] = it.scale_value;
			return;
		end
		diff = 17'(it.coord_a) - 17'(it.coord_b);
		mag = diff[16] ? 17'(-diff) : 17'(diff);
		v = (64'(mag) * 64'(m_scales[it.dim_index])) >> 4;
		term = clip_u32((v * v) >> 16, m_sat);
		m_dist = clip_u32(64'(m_dist) + 64'(term), m_sat);
		if (m_deriv_sel >= 1 && m_deriv_sel - 1 == 5'(it.dim_index))
			m_sel_term = term;
		if (!it.last_element)
			return;
		s = m_sat;
		base = (64'(m_out_scale) * 64'(exp_half_neg(m_dist))) >> 8;
		res = '0;
		if (m_deriv_sel == 0)
			res.kernel_value = base[31:0];
		else if (m_deriv_sel <= m_num_dims)
			res.kernel_value = clip_u32((base * 64'(m_sel_term)) >> 16, s);
		else if (6'(m_deriv_sel) == 6'(m_num_dims) + 6'd1)
			res.kernel_value = 32'(base * 2);
		else
			res.index_error = 1'b1;
		res.saturated = s;
		expected_kernels.push_back(res);
		m_dist = 0;
		m_sel_term = 0;
		m_sat = 0;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			seard_pkg::CFG_OUTPUT_SCALE: m_out_scale = val;
			seard_pkg::CFG_DERIV_SELECT: m_deriv_sel = val[4:0];
			default: m_num_dims = val[4:0];
		endcase
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || expected_kernels.size() != 0 || in_valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic seard_pkg::in_item_t make_load(input int d, input logic [15:0] sv);
		seard_pkg::in_item_t it;
		it = '0;
		it.operation = seard_pkg::OP_LOAD;
		it.dim_index = 4'(d);
		it.scale_value = sv;
		it.last_element = 1'($urandom_range(0, 1));
		it.coord_a = 16'($urandom);
		it.coord_b = 16'($urandom);
		return it;
	endfunction

	function automatic seard_pkg::in_item_t make_coord(input int d, input logic [15:0] a,
		input logic [15:0] b, input bit last);
		seard_pkg::in_item_t it;
		it = '0;
		it.operation = seard_pkg::OP_COORD;
		it.dim_index = 4'(d);
		it.coord_a = a;
		it.coord_b = b;
		it.scale_value = 16'($urandom);
		it.last_element = last;
		return it;
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 1023)) - 16'd512;
			default: return 16'($urandom_range(0, 8191)) - 16'd4096;
		endcase
	endfunction

	// one point pair of ndims items; dim k, or a random dim one time in four; last one flagged
	task automatic push_pair(input int ndims);
		for (int k = 0; k < ndims; k++)
			pending_items.push_back(make_coord(($urandom_range(0, 3) == 0)
				? $urandom_range(0, 15) : k, rand_coord(), rand_coord(), k == ndims - 1));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: a new item only once the current one was taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else if (!in_valid || in_taken) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
				in_valid <= 1'b1;
				in_item <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// prediction at acceptance
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			predict_kernel(in_item);
	end

	// receiver stall
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req && !hold_used) begin
			out_stall <= 1'b1;
			hold_used <= 1'b1;
			hold_cycles <= HOLD_LEN - 1;
		end else if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < out_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		seard_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_kernels.size() == 0) begin
				report_mismatch("unexpected item", out_item.kernel_value, 0);
			end else begin
				want = expected_kernels.pop_front();
				if (out_item.kernel_value !== want.kernel_value)
					report_mismatch("kernel_value", out_item.kernel_value, want.kernel_value);
				if (out_item.index_error !== want.index_error)
					report_mismatch("index_error", out_item.index_error, want.index_error);
				if (out_item.saturated !== want.saturated)
					report_mismatch("saturated", out_item.saturated, want.saturated);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n ||
			(pending_items.size() == 0 && expected_kernels.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("se_ard_covariance_kernel_top test failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		in_idle_pct = 12;
		out_idle_pct = 67;
		cfg_we = 1'b0;
		cfg_index = seard_pkg::CFG_OUTPUT_SCALE;
		cfg_data = '0;
		m_out_scale = seard_pkg::OUTPUT_SCALE_RST;
		m_deriv_sel = '0;
		m_num_dims = seard_pkg::NUM_DIMS_RST;
		m_dist = '0;
		m_sel_term = '0;
		m_sat = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fill whole table first, extremes included
		pending_items.push_back(make_load(0, 16'hFFFF));
		pending_items.push_back(make_load(1, 16'h0000));
		for (int d = 2; d < 16; d++)
			pending_items.push_back(make_load(d, 16'h1000));
		pending_items.push_back(make_coord(0, 16'h7FFF, 16'h8000, 1)); // saturating
		pending_items.push_back(make_coord(2, 16'h0000, 16'h0000, 1)); // d = 0
		pending_items.push_back(make_coord(2, 16'h0100, 16'hFF00, 0));
		pending_items.push_back(make_coord(1, 16'h8000, 16'h7FFF, 1));
		pending_items.push_back(make_coord(3, 16'h0800, 16'h0000, 1)); // exp underflows
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				in_idle_pct = 67;
				out_idle_pct = 12;
			end else if (ph == 4) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			case (ph)
				0: begin
					write_reg(seard_pkg::CFG_OUTPUT_SCALE, 16'hFFFF);
					write_reg(seard_pkg::CFG_NUM_DIMS, 5'd16);
					write_reg(seard_pkg::CFG_DERIV_SELECT, 5'd1);
				end
				1: begin
					write_reg(seard_pkg::CFG_OUTPUT_SCALE, 16'h0000);
					write_reg(seard_pkg::CFG_NUM_DIMS, 5'd1);
					write_reg(seard_pkg::CFG_DERIV_SELECT, 5'd2);
				end
				2: begin
					write_reg(seard_pkg::CFG_OUTPUT_SCALE, 16'($urandom));
					write_reg(seard_pkg::CFG_NUM_DIMS, 5'd4);
					write_reg(seard_pkg::CFG_DERIV_SELECT, 5'd31); // out of range
				end
				3: begin
					write_reg(seard_pkg::CFG_OUTPUT_SCALE, 16'h0100);
					write_reg(seard_pkg::CFG_NUM_DIMS, 5'd0);
					write_reg(seard_pkg::CFG_DERIV_SELECT, 5'd0);
				end
				4: begin
					write_reg(seard_pkg::CFG_OUTPUT_SCALE, 16'($urandom));
					write_reg(seard_pkg::CFG_NUM_DIMS, 5'd16);
					write_reg(seard_pkg::CFG_DERIV_SELECT, 5'd17);
				end
				default: begin
					write_reg(seard_pkg::CFG_NUM_DIMS, 5'($urandom_range(1, 16)));
					write_reg(seard_pkg::CFG_DERIV_SELECT, 5'($urandom_range(0, 18)));
				end
			endcase
			for (int n = 0; n < 75; ) begin
				if ($urandom_range(0, 9) == 0) begin
					pending_items.push_back(make_load($urandom_range(0, 15),
						16'($urandom_range(0, 8191))));
					n++;
				end else begin
					int nd;
					nd = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 4);
					push_pair(nd);
					n += nd;
				end
			end
			if (ph == 4) begin
				@(negedge clk);
				hold_req = 1'b1;
			end
			wait_idle();
		end

		if (errors == 0)
			$display("se_ard_covariance_kernel_top test passed");
		else
			$display("se_ard_covariance_kernel_top test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
src/seard_pkg.sv
src/seard_ram.sv
src/seard_ctrl.sv
src/seard_dp.sv
src/se_ard_covariance_kernel_top.sv
verif/tb_top.sv
